@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bbd_pkg.sv @@
// Shared types and constants of the button bank debouncer.
package bbd_pkg;

    // Fixed field widths of the scan and result items, the configuration registers and the APB port.
    localparam int LINE_W    = 8;
    localparam int TICK_IN_W = 32;
    localparam int SETTLE_W  = 32;
    localparam int ACTIVE_W  = 4;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Configuration reset values.
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 32'd5;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    // Register index, taken from address bit 2.
    typedef enum logic {
        REG_SETTLE = 1'b0,
        REG_ACTIVE = 1'b1
    } reg_idx_t;

    // Per-button phase machine.
    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_PRESSED  = 3'b010,
        PH_RELEASED = 3'b100
    } phase_t;

endpackage

@@ hdl/bbd_if.sv @@
// Handshake interfaces for scan items and result items.
interface bbd_scan_if;
    logic                         valid;
    logic                         ready;
    logic [bbd_pkg::LINE_W-1:0]    raw_levels;
    logic [bbd_pkg::TICK_IN_W-1:0] tick_now;

    modport source (output valid, raw_levels, tick_now, input ready);
    modport sink   (input valid, raw_levels, tick_now, output ready);
endinterface

interface bbd_result_if;
    logic                      valid;
    logic                      ready;
    logic [bbd_pkg::LINE_W-1:0] released_mask;
    logic [bbd_pkg::LINE_W-1:0] stable_pressed;

    modport source (output valid, released_mask, stable_pressed, input ready);
    modport sink   (input valid, released_mask, stable_pressed, output ready);
endinterface

@@ hdl/button_bank_debouncer.sv @@
// A scan item passes the input register, then the result register; one item per cycle
// unless the output stalls. The path is one tick subtract and compare per button.
// Each button is updated in parallel between the input register and the result register.
// Reset (rst_n low, asynchronous) clears all button state and empties both registers.
// After reset settle_reg is 5 and active_reg is 8; no clearing pass is needed.
module button_bank_debouncer #(
    parameter int NUM_BUTTONS = 8,
    parameter int TICK_WIDTH  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bbd_scan_if.sink                     scan,
    bbd_result_if.source                 result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbd_pkg::APB_AW-1:0]   paddr,
    input  logic [bbd_pkg::APB_DW-1:0]   pwdata,
    output logic [bbd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int CmpW = (TICK_WIDTH > bbd_pkg::SETTLE_W) ? TICK_WIDTH : bbd_pkg::SETTLE_W;
    localparam int ExtW = (CmpW > bbd_pkg::TICK_IN_W) ? CmpW : bbd_pkg::TICK_IN_W;
    localparam logic [bbd_pkg::ACTIVE_W-1:0] NumBtn = bbd_pkg::ACTIVE_W'(NUM_BUTTONS);

    // Configuration registers.
    logic [bbd_pkg::SETTLE_W-1:0] settle_reg;
    logic [bbd_pkg::ACTIVE_W-1:0] active_reg;

    // Input register.
    logic                          in_v_reg;
    logic                          in_v_next;
    logic [bbd_pkg::LINE_W-1:0]    raw_reg;
    logic [bbd_pkg::TICK_IN_W-1:0] tick_reg;

    // Result register.
    logic                          out_v_reg;
    logic                          out_v_next;
    logic [bbd_pkg::LINE_W-1:0]    rel_reg;
    logic [bbd_pkg::LINE_W-1:0]    rel_next;
    logic [bbd_pkg::LINE_W-1:0]    stab_reg;
    logic [bbd_pkg::LINE_W-1:0]    stab_next;

    // Per-button state.
    logic [TICK_WIDTH-1:0]  start_tick_reg  [NUM_BUTTONS];
    logic [TICK_WIDTH-1:0]  start_tick_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] start_lvl_reg;
    logic [NUM_BUTTONS-1:0] start_lvl_next;
    logic [NUM_BUTTONS-1:0] flag_reg;
    logic [NUM_BUTTONS-1:0] flag_next;
    logic [NUM_BUTTONS-1:0] lvl_reg;
    logic [NUM_BUTTONS-1:0] lvl_next;
    bbd_pkg::phase_t        phase_reg  [NUM_BUTTONS];
    bbd_pkg::phase_t        phase_next [NUM_BUTTONS];

    logic                          fire;
    logic                          in_take;
    logic                          cfg_wr;
    logic [bbd_pkg::ACTIVE_W-1:0]  count;
    logic [ExtW-1:0]               tick_ext;
    logic [TICK_WIDTH-1:0]         now;

    // Handshake: the input register moves on whenever the result register is free.
    assign fire         = in_v_reg && (!out_v_reg || result.ready);
    assign scan.ready   = !in_v_reg || fire;
    assign in_take      = scan.valid && scan.ready;
    assign in_v_next    = in_take ? 1'b1 : (fire ? 1'b0 : in_v_reg);
    assign out_v_next   = fire ? 1'b1 : (result.ready ? 1'b0 : out_v_reg);

    assign result.valid          = out_v_reg;
    assign result.released_mask  = rel_reg;
    assign result.stable_pressed = stab_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (bbd_pkg::reg_idx_t'(paddr[2]))
            bbd_pkg::REG_SETTLE: prdata = settle_reg;
            bbd_pkg::REG_ACTIVE: prdata = bbd_pkg::APB_DW'(active_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= bbd_pkg::SETTLE_RESET;
            active_reg <= bbd_pkg::ACTIVE_RESET;
        end
        else if (cfg_wr)
        begin
            case (bbd_pkg::reg_idx_t'(paddr[2]))
                bbd_pkg::REG_SETTLE: settle_reg <= pwdata;
                bbd_pkg::REG_ACTIVE: active_reg <= pwdata[bbd_pkg::ACTIVE_W-1:0];
                default:             settle_reg <= settle_reg;
            endcase
        end
    end

    // Clamp the active count and fit the tick to the tick width.
    assign count    = (active_reg > NumBtn) ? NumBtn : active_reg;
    assign tick_ext = ExtW'(tick_reg);
    assign now      = tick_ext[TICK_WIDTH-1:0];

    // Per-button update, all buttons side by side.
    always_comb
    begin
        logic                  level;
        logic [TICK_WIDTH-1:0] elapsed;
        logic                  expired;
        logic                  flg;
        logic                  slv;

        start_tick_next = start_tick_reg;
        start_lvl_next  = start_lvl_reg;
        flag_next       = flag_reg;
        lvl_next        = lvl_reg;
        phase_next      = phase_reg;
        rel_next        = '0;
        stab_next       = '0;

        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            level   = ~raw_reg[i];
            elapsed = now - start_tick_reg[i];
            expired = CmpW'(elapsed) > CmpW'(settle_reg);
            flg     = flag_reg[i];
            slv     = lvl_reg[i];

            if (fire && (bbd_pkg::ACTIVE_W'(i) < count))
            begin
                // Once the window has run out, restart on a change or settle the level.
                if (expired)
                begin
                    if (start_lvl_reg[i] != level)
                    begin
                        start_tick_next[i] = now;
                        start_lvl_next[i]  = level;
                        flg                = 1'b0;
                    end
                    else
                    begin
                        slv = level;
                        flg = 1'b1;
                    end
                end

                // Phase machine; a settled release after a press raises the event.
                if (flg)
                begin
                    if (slv)
                    begin
                        phase_next[i] = bbd_pkg::PH_PRESSED;
                    end
                    else
                    begin
                        rel_next[i]   = (phase_reg[i] == bbd_pkg::PH_PRESSED);
                        phase_next[i] = bbd_pkg::PH_RELEASED;
                    end
                end

                flag_next[i] = flg;
                lvl_next[i]  = slv;
            end

            stab_next[i] = lvl_next[i];
        end
    end

    // Control registers and button state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg      <= 1'b0;
            out_v_reg     <= 1'b0;
            start_lvl_reg <= '0;
            flag_reg      <= '0;
            lvl_reg       <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                start_tick_reg[i] <= '0;
                phase_reg[i]      <= bbd_pkg::PH_IDLE;
            end
        end
        else
        begin
            in_v_reg       <= in_v_next;
            out_v_reg      <= out_v_next;
            start_lvl_reg  <= start_lvl_next;
            flag_reg       <= flag_next;
            lvl_reg        <= lvl_next;
            start_tick_reg <= start_tick_next;
            phase_reg      <= phase_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            raw_reg  <= scan.raw_levels;
            tick_reg <= scan.tick_now;
        end
        if (fire)
        begin
            rel_reg  <= rel_next;
            stab_reg <= stab_next;
        end
    end

endmodule

@@ hdl/bbd_checker.sv @@
// Port-level checker for the button bank debouncer, bound to the top level.
`include "assert_macros.svh"

module bbd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       scan_valid,
    input logic                       scan_ready,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic [bbd_pkg::LINE_W-1:0] released_mask,
    input logic [bbd_pkg::LINE_W-1:0] stable_pressed
);

    // A released button has a settled level of not pressed.
    `BBD_ASSERT_IMPLY(a_rel_not_pressed, clk, rst_n, result_valid, ((released_mask & stable_pressed) == '0), "released button still shows pressed")

    // The input side only stalls when both registers are full and the output is blocked.
    `BBD_ASSERT_IMPLY(a_stall_cause, clk, rst_n, !scan_ready, (result_valid && !result_ready), "input stalled without output backpressure")

    // A stalled result stays offered.
    `BBD_ASSERT_NEXT(a_out_hold, clk, rst_n, (result_valid && !result_ready), result_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `BBD_ASSERT_NEXT(a_out_stable, clk, rst_n, (result_valid && !result_ready), ($stable(released_mask) && $stable(stable_pressed)), "result changed while stalled")

endmodule

bind button_bank_debouncer bbd_checker u_bbd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .scan_valid     (scan.valid),
    .scan_ready     (scan.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .released_mask  (result.released_mask),
    .stable_pressed (result.stable_pressed)
);
